// ===== rtl/priority_queue_with_history_stack_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority queue with history stack
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_WITH_HISTORY_STACK_ASSERT_SVH
`define PRIORITY_QUEUE_WITH_HISTORY_STACK_ASSERT_SVH

`ifndef SYNTH
// Checks a property at every rising clock edge outside reset.
`define PQHS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Checks that a condition in one cycle implies another in the next cycle.
`define PQHS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define PQHS_ASSERT(lbl, clk, rst_n, prop)
`define PQHS_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== rtl/pqhs_pkg.sv =====
// ----------------------------------------------------------------------------
// pqhs_pkg
// Shared types and sizes of the service queue and history stack.
// ----------------------------------------------------------------------------
`default_nettype none

package pqhs_pkg;

	localparam int QUEUE_DEPTH   = 128;
	localparam int HISTORY_DEPTH = 128;

	localparam int Q_AW = $clog2(QUEUE_DEPTH);
	localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);
	localparam int Q_SW = $clog2(2 * QUEUE_DEPTH);
	localparam int H_AW = $clog2(HISTORY_DEPTH);
	localparam int H_CW = $clog2(HISTORY_DEPTH + 1);

	localparam int ID_W    = 16;
	localparam int PRICE_W = 24;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 8;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PRICE_W-1:0] price;
	} entry_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ  = 3'd0,
		CMD_URG  = 3'd1,
		CMD_CALL = 3'd2,
		CMD_POP  = 3'd3,
		CMD_PEEK = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_Q_FULL  = 3'd1,
		STAT_Q_EMPTY = 3'd2,
		STAT_H_FULL  = 3'd3,
		STAT_H_EMPTY = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic issue;  // a command transaction is taken this cycle
		logic exec;   // memory read data of the command is available
		logic load;   // the result register takes the finished result
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/pqhs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pqhs_ctrl
// Command sequencer and result handshake of the queue and history stack.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_queue_with_history_stack_assert.svh"

module pqhs_ctrl import pqhs_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  wire  m_tready,
	output ctl_t ctl
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ctl.issue = 1'b0;
		ctl.exec  = 1'b0;
		ctl.load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				ctl.issue = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				// The result register may take a new result once it is empty or drains now.
				ctl.load = !out_valid_q || m_tready;
				if (ctl.load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		out_valid_d = ctl.load || (out_valid_q && !m_tready);
	end

	assign m_tvalid = out_valid_q;

	`PQHS_ASSERT_NEXT(a_issue_exec, clk, arst_n, ctl.issue, state_q == ST_EXEC)
	`PQHS_ASSERT_NEXT(a_load_valid, clk, arst_n, ctl.load, out_valid_q)
	`PQHS_ASSERT_NEXT(a_hold_exec, clk, arst_n,
		state_q == ST_EXEC && out_valid_q && !m_tready, state_q == ST_EXEC)

endmodule

`default_nettype wire

// ===== rtl/pqhs_dp.sv =====
// ----------------------------------------------------------------------------
// pqhs_dp
// Queue and history memories, pointers, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_queue_with_history_stack_assert.svh"

module pqhs_dp import pqhs_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire  ctl_t         ctl,
	input  wire  [CMD_W-1:0]   cmd,
	input  wire  [ID_W-1:0]    pet_id,
	input  wire  [PRICE_W-1:0] price,
	output logic [STAT_W-1:0]  status,
	output logic               item_valid,
	output logic [ID_W-1:0]    item_id,
	output logic [PRICE_W-1:0] item_price,
	output logic               top_valid,
	output logic [ID_W-1:0]    top_id,
	output logic [PRICE_W-1:0] top_price,
	output logic [CNT_W-1:0]   queue_count,
	output logic [CNT_W-1:0]   history_count
);

	entry_t q_mem [QUEUE_DEPTH];
	entry_t h_mem [HISTORY_DEPTH];

	logic [Q_AW-1:0] q_head_q, q_head_d;
	logic [Q_CW-1:0] q_fill_q, q_fill_d;
	logic [H_CW-1:0] h_fill_q, h_fill_d;

	entry_t          q_rd_q, h_rd_q;
	logic [STAT_W-1:0] status_s1;
	logic            ivalid_s1, tvalid_s1, from_hist_s1, hwr_s1;
	logic [H_AW-1:0] hwr_addr_s1;

	logic            q_full, q_empty, h_full, h_empty;
	logic [Q_SW-1:0] tail_sum;
	logic [Q_AW-1:0] tail, head_dec, head_inc;
	logic [H_AW-1:0] h_top;
	logic            q_we, q_re, h_re;
	logic [Q_AW-1:0] q_waddr;
	status_t         status_d;
	logic            ivalid_d, tvalid_d, from_hist_d, hwr_d;
	entry_t          ent;
	entry_t          item_sel;

	assign ent.id    = pet_id;
	assign ent.price = price;

	assign q_full  = q_fill_q == Q_CW'(QUEUE_DEPTH);
	assign q_empty = q_fill_q == '0;
	assign h_full  = h_fill_q == H_CW'(HISTORY_DEPTH);
	assign h_empty = h_fill_q == '0;

	// Circular index arithmetic; head plus fill stays below twice the depth.
	assign tail_sum = Q_SW'(q_head_q) + Q_SW'(q_fill_q);
	assign tail     = (tail_sum >= Q_SW'(QUEUE_DEPTH)) ? Q_AW'(tail_sum - Q_SW'(QUEUE_DEPTH))
	                                                    : Q_AW'(tail_sum);
	assign head_dec = (q_head_q == '0) ? Q_AW'(QUEUE_DEPTH - 1) : q_head_q - 1'b1;
	assign head_inc = (q_head_q == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : q_head_q + 1'b1;
	assign h_top    = H_AW'(h_fill_q - 1'b1);

	always_comb begin
		q_head_d    = q_head_q;
		q_fill_d    = q_fill_q;
		h_fill_d    = h_fill_q;
		q_we        = 1'b0;
		q_re        = 1'b0;
		h_re        = 1'b0;
		q_waddr     = tail;
		status_d    = STAT_OK;
		ivalid_d    = 1'b0;
		tvalid_d    = 1'b0;
		from_hist_d = 1'b0;
		hwr_d       = 1'b0;
		unique case (cmd)
			CMD_ENQ: begin
				if (q_full) begin
					status_d = STAT_Q_FULL;
				end else begin
					q_we     = 1'b1;
					q_fill_d = q_fill_q + 1'b1;
				end
			end
			CMD_URG: begin
				if (q_full) begin
					status_d = STAT_Q_FULL;
				end else begin
					q_we     = 1'b1;
					q_waddr  = head_dec;
					q_head_d = head_dec;
					q_fill_d = q_fill_q + 1'b1;
				end
			end
			CMD_CALL: begin
				if (q_empty) begin
					status_d = STAT_Q_EMPTY;
				end else begin
					q_re     = 1'b1;
					ivalid_d = 1'b1;
					q_head_d = head_inc;
					q_fill_d = q_fill_q - 1'b1;
					if (h_full) begin
						status_d = STAT_H_FULL;
					end else begin
						hwr_d    = 1'b1;
						h_fill_d = h_fill_q + 1'b1;
					end
				end
			end
			CMD_POP: begin
				if (h_empty) begin
					status_d = STAT_H_EMPTY;
				end else begin
					h_re        = 1'b1;
					ivalid_d    = 1'b1;
					from_hist_d = 1'b1;
					h_fill_d    = h_fill_q - 1'b1;
				end
			end
			CMD_PEEK: begin
				q_re     = !q_empty;
				ivalid_d = !q_empty;
				h_re     = !h_empty;
				tvalid_d = !h_empty;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q <= '0;
			q_fill_q <= '0;
			h_fill_q <= '0;
		end else if (ctl.issue) begin
			q_head_q <= q_head_d;
			q_fill_q <= q_fill_d;
			h_fill_q <= h_fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			status_s1    <= status_d;
			ivalid_s1    <= ivalid_d;
			tvalid_s1    <= tvalid_d;
			from_hist_s1 <= from_hist_d;
			hwr_s1       <= hwr_d;
			hwr_addr_s1  <= H_AW'(h_fill_q);
		end
	end

	// Queue memory: one write or one read per command.
	always_ff @(posedge clk) begin
		if (ctl.issue && q_we) begin
			q_mem[q_waddr] <= ent;
		end
		if (ctl.issue && q_re) begin
			q_rd_q <= q_mem[q_head_q];
		end
	end

	// History memory: read on issue, the called entry is recorded once it is read.
	always_ff @(posedge clk) begin
		if (ctl.exec && hwr_s1) begin
			h_mem[hwr_addr_s1] <= q_rd_q;
		end
		if (ctl.issue && h_re) begin
			h_rd_q <= h_mem[h_top];
		end
	end

	assign item_sel = from_hist_s1 ? h_rd_q : q_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			status        <= status_s1;
			item_valid    <= ivalid_s1;
			item_id       <= ivalid_s1 ? item_sel.id : '0;
			item_price    <= ivalid_s1 ? item_sel.price : '0;
			top_valid     <= tvalid_s1;
			top_id        <= tvalid_s1 ? h_rd_q.id : '0;
			top_price     <= tvalid_s1 ? h_rd_q.price : '0;
			queue_count   <= CNT_W'(q_fill_q);
			history_count <= CNT_W'(h_fill_q);
		end
	end

	`PQHS_ASSERT(a_q_fill_max, clk, arst_n, q_fill_q <= Q_CW'(QUEUE_DEPTH))
	`PQHS_ASSERT(a_h_fill_max, clk, arst_n, h_fill_q <= H_CW'(HISTORY_DEPTH))
	`PQHS_ASSERT_NEXT(a_call_dec, clk, arst_n,
		ctl.issue && cmd == CMD_CALL && !q_empty, q_fill_q + 1'b1 == $past(q_fill_q))

endmodule

`default_nettype wire

// ===== rtl/priority_queue_with_history_stack.sv =====
// ----------------------------------------------------------------------------
// priority_queue_with_history_stack
// Service queue with back and front insertion plus a history stack of called
// entries, driven by one command transaction and answering with one result.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_*       in         command transaction: cmd, pet_id, price
//  m_*       out        result transaction: status, item and top entries, counts
//
// Every command passes through an issue step and an execute step: the
// issue step updates pointers and counters and issues the memory accesses,
// the execute step takes the registered memory read data into the result register.
// A new command is taken only after the last one leaves its execute step, as
// set by the registered read of both memories and the history write after it.
// After reset both stores are empty; no clearing pass is made.
// While a result waits in the output register, the next command is still
// taken, and its result waits in the execute step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_queue_with_history_stack import pqhs_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// [2:0] cmd, [18:3] pet_id, [42:19] price, [47:43] zero
	input  wire  [47:0]  s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// [2:0] status, [3] item_valid, [19:4] item_id, [43:20] item_price,
	// [44] top_valid, [60:45] top_id, [84:61] top_price, [92:85] queue_count,
	// [100:93] history_count, [103:101] zero
	output logic [103:0] m_tdata
);

	// Commands from the sequencer to the datapath.
	ctl_t ctl;

	logic [STAT_W-1:0]  status;
	logic               item_valid, top_valid;
	logic [ID_W-1:0]    item_id, top_id;
	logic [PRICE_W-1:0] item_price, top_price;
	logic [CNT_W-1:0]   queue_count, history_count;

	// The sequencer accepts a command only while idle and owns the result valid.
	pqhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl)
	);

	// The datapath holds both memories, the pointers and the result payload.
	pqhs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (s_tdata[2:0]),
		.pet_id        (s_tdata[18:3]),
		.price         (s_tdata[42:19]),
		.status        (status),
		.item_valid    (item_valid),
		.item_id       (item_id),
		.item_price    (item_price),
		.top_valid     (top_valid),
		.top_id        (top_id),
		.top_price     (top_price),
		.queue_count   (queue_count),
		.history_count (history_count)
	);

	// Result fields packed from the lowest bit up, padded to whole bytes.
	assign m_tdata = {3'b000, history_count, queue_count, top_price, top_id, top_valid,
	                  item_price, item_id, item_valid, status};

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the service queue with history stack. A short
// table of commands covers the empty and reserved cases and the extreme
// entries. Long random runs follow, each biased toward filling, draining or
// popping or evenly mixed. Every result transaction is checked against a
// predictor that keeps its own copy of the queue and the stack.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import pqhs_pkg::*; ();

	// Command codes that the block does not decode. They must leave the
	// state alone and answer with an all-zero result apart from the counts.
	localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 8;
	localparam int RUN_BLOCKS   = 8;
	localparam int BLOCK_ITEMS  = 240;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_CYCLES = 500000;

	// One result transaction, laid out exactly as on m_tdata[100:0], so that
	// the monitor can take it with a plain cast.
	typedef struct packed {
		logic [CNT_W-1:0]   history_count;
		logic [CNT_W-1:0]   queue_count;
		logic [PRICE_W-1:0] top_price;
		logic [ID_W-1:0]    top_id;
		logic               top_valid;
		logic [PRICE_W-1:0] item_price;
		logic [ID_W-1:0]    item_id;
		logic               item_valid;
		logic [STAT_W-1:0]  status;
	} result_t;

	// One row of the directed table. Where fixed is set, the result is fully
	// known from the row itself: status and counts, with all entries zero.
	typedef struct packed {
		logic [CMD_W-1:0]   op;
		logic [ID_W-1:0]    id;
		logic [PRICE_W-1:0] price;
		logic               fixed;
		logic [STAT_W-1:0]  status;
		logic [CNT_W-1:0]   queue_count;
		logic [CNT_W-1:0]   history_count;
	} step_t;

	// Command mixes of the random part.
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_POP,
		MIX_EVEN
	} mix_t;

	localparam int DIRECTED_ROWS = 26;

	localparam step_t DIRECTED [DIRECTED_ROWS] = '{
		// Everything empty straight after reset.
		'{CMD_PEEK,  16'h0000, 24'h000000, 1'b1, STAT_OK,      8'd0, 8'd0},
		'{CMD_CALL,  16'h0000, 24'h000000, 1'b1, STAT_Q_EMPTY, 8'd0, 8'd0},
		'{CMD_POP,   16'h0000, 24'h000000, 1'b1, STAT_H_EMPTY, 8'd0, 8'd0},
		// Reserved codes, with payloads that must be ignored.
		'{CMD_RSVD5, 16'hFFFF, 24'hFFFFFF, 1'b1, STAT_OK,      8'd0, 8'd0},
		'{CMD_RSVD6, 16'h0000, 24'h000000, 1'b1, STAT_OK,      8'd0, 8'd0},
		'{CMD_RSVD7, 16'hAAAA, 24'h555555, 1'b1, STAT_OK,      8'd0, 8'd0},
		// Extreme entries at the back of the queue.
		'{CMD_ENQ,   16'h0000, 24'h000000, 1'b1, STAT_OK,      8'd1, 8'd0},
		'{CMD_ENQ,   16'hFFFF, 24'hFFFFFF, 1'b1, STAT_OK,      8'd2, 8'd0},
		// From here on the predictor supplies the expected result.
		'{CMD_URG,   16'h8001, 24'h800001, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_PEEK,  16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_CALL,  16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_PEEK,  16'hFFFF, 24'hFFFFFF, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_URG,   16'h7FFE, 24'h7FFFFE, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_CALL,  16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_CALL,  16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_PEEK,  16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_POP,   16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_POP,   16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_CALL,  16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_CALL,  16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_PEEK,  16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_POP,   16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_POP,   16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_POP,   16'h0000, 24'h000000, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_ENQ,   16'h5A5A, 24'hA5A5A5, 1'b0, STAT_OK,      8'd0, 8'd0},
		'{CMD_RSVD7, 16'hFFFF, 24'hFFFFFF, 1'b0, STAT_OK,      8'd0, 8'd0}
	};

	localparam mix_t SCHEDULE [RUN_BLOCKS] = '{
		MIX_FILL, MIX_DRAIN, MIX_POP, MIX_EVEN,
		MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_EVEN
	};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;

	// Predictor state: the circular service queue and the history stack.
	entry_t  line_store [QUEUE_DEPTH];
	int      line_head;
	int      line_fill;
	entry_t  hist_store [HISTORY_DEPTH];
	int      hist_fill;

	// Results still owed by the block, oldest first.
	result_t pending_results [$];

	int      errors;
	int      idle_pct;
	int      stall_left;
	result_t mon_got;
	result_t mon_want;

	priority_queue_with_history_stack u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Applies one command to the predictor state and returns the result that
	// the block must give for it. Entries are read only where they exist, so
	// the never-written parts of both stores are never touched.
	function automatic result_t serve_command(input logic [CMD_W-1:0] op,
			input entry_t ent);
		result_t r;
		entry_t  taken;
		r = '0;
		r.status = STAT_OK;
		case (op)
			CMD_ENQ: begin
				if (line_fill >= QUEUE_DEPTH) begin
					r.status = STAT_Q_FULL;
				end else begin
					line_store[(line_head + line_fill) % QUEUE_DEPTH] = ent;
					line_fill++;
				end
			end
			CMD_URG: begin
				if (line_fill >= QUEUE_DEPTH) begin
					r.status = STAT_Q_FULL;
				end else begin
					line_head = (line_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
					line_store[line_head] = ent;
					line_fill++;
				end
			end
			CMD_CALL: begin
				if (line_fill == 0) begin
					r.status = STAT_Q_EMPTY;
				end else begin
					taken = line_store[line_head];
					r.item_valid = 1'b1;
					r.item_id    = taken.id;
					r.item_price = taken.price;
					line_head = (line_head + 1) % QUEUE_DEPTH;
					line_fill--;
					// A full history still hands the entry out, it just
					// does not remember it.
					if (hist_fill >= HISTORY_DEPTH) begin
						r.status = STAT_H_FULL;
					end else begin
						hist_store[hist_fill] = taken;
						hist_fill++;
					end
				end
			end
			CMD_POP: begin
				if (hist_fill == 0) begin
					r.status = STAT_H_EMPTY;
				end else begin
					hist_fill--;
					taken = hist_store[hist_fill];
					r.item_valid = 1'b1;
					r.item_id    = taken.id;
					r.item_price = taken.price;
				end
			end
			CMD_PEEK: begin
				if (line_fill != 0) begin
					taken = line_store[line_head];
					r.item_valid = 1'b1;
					r.item_id    = taken.id;
					r.item_price = taken.price;
				end
				if (hist_fill != 0) begin
					taken = hist_store[hist_fill - 1];
					r.top_valid = 1'b1;
					r.top_id    = taken.id;
					r.top_price = taken.price;
				end
			end
			default: begin
			end
		endcase
		r.queue_count   = CNT_W'(line_fill);
		r.history_count = CNT_W'(hist_fill);
		return r;
	endfunction

	// Offers one command transaction, holds it until it is taken, and files
	// the result it owes. A fixed result replaces the predicted one, but the
	// predictor is stepped either way so that its state stays in line.
	task automatic send_command(input logic [CMD_W-1:0] op, input entry_t ent,
			input logic fixed, input result_t fixed_result);
		result_t predicted;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, ent.price, ent.id, op};
		do @(posedge clk); while (!s_tready);
		predicted = serve_command(op, ent);
		pending_results.push_back(fixed ? fixed_result : predicted);
	endtask

	// Drops valid for the given number of cycles. The payload is scrambled
	// meanwhile, since the block must not look at it.
	task automatic hold_off(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tdata  <= 48'({$urandom, $urandom});
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stops offering commands until the block owes nothing more.
	task automatic settle;
		hold_off(1);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic maybe_idle;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
			hold_off($urandom_range(1, 9));
	endtask

	// Ids and prices favor the all-zero and all-one patterns now and then.
	function automatic entry_t pick_entry;
		entry_t e;
		e.id    = ID_W'($urandom);
		e.price = PRICE_W'($urandom);
		case ($urandom_range(0, 7))
			0: e = '0;
			1: e = '1;
			2: e.id = '1;
			3: e.price = '0;
			default: begin
			end
		endcase
		return e;
	endfunction

	// Picks a command code for the given mix. A small share of reserved
	// codes is sprinkled in everywhere.
	function automatic logic [CMD_W-1:0] pick_op(input mix_t mix);
		int w_enq;
		int w_urg;
		int w_call;
		int w_pop;
		int roll;
		case (mix)
			MIX_FILL:  begin w_enq = 45; w_urg = 35; w_call = 10; w_pop = 5;  end
			MIX_DRAIN: begin w_enq = 5;  w_urg = 5;  w_call = 80; w_pop = 5;  end
			MIX_POP:   begin w_enq = 10; w_urg = 5;  w_call = 10; w_pop = 70; end
			default:   begin w_enq = 20; w_urg = 20; w_call = 20; w_pop = 20; end
		endcase
		if ($urandom_range(0, 99) < 2)
			return CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
		roll = $urandom_range(0, 99);
		if (roll < w_enq)
			return CMD_ENQ;
		roll -= w_enq;
		if (roll < w_urg)
			return CMD_URG;
		roll -= w_urg;
		if (roll < w_call)
			return CMD_CALL;
		roll -= w_call;
		if (roll < w_pop)
			return CMD_POP;
		return CMD_PEEK;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, name, want, got);
		end
	endtask

	// The receiver stalls in bursts of random length, at the same rate
	// as the sender idles, so that a full result register and a waiting
	// command in the execute step both get exercised.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Every result transaction is matched against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mon_got = result_t'(m_tdata[100:0]);
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual %0h",
					$time, m_tdata);
			end else begin
				mon_want = pending_results.pop_front();
				check_field("status", mon_want.status, mon_got.status);
				check_field("item_valid", mon_want.item_valid, mon_got.item_valid);
				check_field("item_id", mon_want.item_id, mon_got.item_id);
				check_field("item_price", mon_want.item_price, mon_got.item_price);
				check_field("top_valid", mon_want.top_valid, mon_got.top_valid);
				check_field("top_id", mon_want.top_id, mon_got.top_id);
				check_field("top_price", mon_want.top_price, mon_got.top_price);
				check_field("queue_count", mon_want.queue_count,
					mon_got.queue_count);
				check_field("history_count", mon_want.history_count,
					mon_got.history_count);
			end
		end
	end

	initial begin
		#(2 * CLK_HALF * LIMIT_CYCLES);
		$display("tb_top failed");
		$finish;
	end

	initial begin
		result_t fixed_result;
		entry_t  ent;
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		errors     = 0;
		stall_left = 0;
		idle_pct   = 30;
		line_head  = 0;
		line_fill  = 0;
		hist_fill  = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed table: empty cases, reserved codes, extreme entries and a
		// short walk through front insertion, calls, peeks and pops.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			fixed_result = '0;
			fixed_result.status        = DIRECTED[i].status;
			fixed_result.queue_count   = DIRECTED[i].queue_count;
			fixed_result.history_count = DIRECTED[i].history_count;
			ent.id    = DIRECTED[i].id;
			ent.price = DIRECTED[i].price;
			maybe_idle();
			send_command(DIRECTED[i].op, ent, DIRECTED[i].fixed, fixed_result);
		end
		settle();

		// Random blocks. A fill block runs the queue into its full case, a
		// drain block moves it into the history until that overflows, and a
		// pop block empties the history again. The last block runs without
		// any idling on either side.
		for (int b = 0; b < RUN_BLOCKS; b++) begin
			if (b == RUN_BLOCKS - 1) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
			end
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				maybe_idle();
				send_command(pick_op(SCHEDULE[b]), pick_entry(), 1'b0, '0);
			end
			// Let the block run dry before the next mix starts.
			settle();
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire
